[rtl/core/esrm_pkg.sv]
// Shared types, register addresses and trim ROM contents for the sensor register model.
// No dependencies; the register bank, read decode and top level import this package.
package esrm_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LOAD  = 2'd2
  } func_e;

  localparam logic [7:0] ADDR_TRIM_A     = 8'h88;
  localparam logic [7:0] ADDR_TRIM_A_END = 8'hA1;
  localparam logic [7:0] ADDR_TRIM_B     = 8'hE1;
  localparam logic [7:0] ADDR_TRIM_B_END = 8'hE7;
  localparam logic [7:0] ADDR_ID         = 8'hD0;
  localparam logic [7:0] ADDR_RESET      = 8'hE0;
  localparam logic [7:0] ADDR_CTRL_HUM   = 8'hF2;
  localparam logic [7:0] ADDR_STATUS     = 8'hF3;
  localparam logic [7:0] ADDR_CTRL_MEAS  = 8'hF4;
  localparam logic [7:0] ADDR_CONFIG     = 8'hF5;
  localparam logic [7:0] ADDR_DATA       = 8'hF7;
  localparam logic [7:0] ADDR_DATA_END   = 8'hFE;

  localparam logic [7:0] CHIP_ID   = 8'h60;
  localparam logic [7:0] RESET_CMD = 8'hB6;

  localparam logic [19:0] TEMP_RESET  = 20'd519888;
  localparam logic [19:0] PRESS_RESET = 20'd415148;
  localparam logic [15:0] HUM_RESET   = 16'd30000;

  // Architectural state of the register bank.
  typedef struct packed {
    logic [2:0]  hum_control;
    logic [7:0]  meas_control;
    logic [7:0]  filter_config;
    logic [19:0] temp_reading;
    logic [19:0] press_reading;
    logic [15:0] hum_reading;
  } sensor_state_t;

  // Update command decoded from one word.
  typedef struct packed {
    logic        soft_reset;
    logic        hum_we;
    logic        meas_we;
    logic        cfg_we;
    logic        load;
    logic [7:0]  wdata;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } reg_cmd_t;

  function automatic logic [7:0] trim_a_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:  b = 8'h70;
      5'd1:  b = 8'h6B;
      5'd2:  b = 8'h43;
      5'd3:  b = 8'h67;
      5'd4:  b = 8'h18;
      5'd5:  b = 8'hFC;
      5'd6:  b = 8'h7D;
      5'd7:  b = 8'h8E;
      5'd8:  b = 8'h43;
      5'd9:  b = 8'hD6;
      5'd10: b = 8'hD0;
      5'd11: b = 8'h0B;
      5'd12: b = 8'h27;
      5'd13: b = 8'h0B;
      5'd14: b = 8'h8C;
      5'd15: b = 8'h00;
      5'd16: b = 8'hF9;
      5'd17: b = 8'hFF;
      5'd18: b = 8'h8C;
      5'd19: b = 8'h3C;
      5'd20: b = 8'hF8;
      5'd21: b = 8'hC6;
      5'd22: b = 8'h70;
      5'd23: b = 8'h17;
      5'd24: b = 8'h00;
      5'd25: b = 8'h4B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trim_b_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h6A;
      3'd1: b = 8'h01;
      3'd2: b = 8'h00;
      3'd3: b = 8'h14;
      3'd4: b = 8'h2E;
      3'd5: b = 8'h03;
      3'd6: b = 8'h1E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/esrm_in_if.sv]
// Input channel of the sensor register model: valid/ready handshake plus one access word.
// Depends on nothing.
interface esrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  addr;
  logic [7:0]  wdata;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, func, addr, wdata, raw_temperature, raw_pressure,
                  raw_humidity, input ready);
  modport sink   (input valid, func, addr, wdata, raw_temperature, raw_pressure,
                  raw_humidity, output ready);
endinterface

[rtl/core/esrm_out_if.sv]
// Output channel of the sensor register model: valid/ready handshake plus read data.
// Depends on nothing.
interface esrm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;

  modport source (output valid, rdata, input ready);
  modport sink   (input valid, rdata, output ready);
endinterface

[rtl/core/esrm_regs.sv]
// State registers of the sensor register model: control registers and raw readings.
// Depends on esrm_pkg.
module esrm_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esrm_pkg::reg_cmd_t     cmd_i,
  output esrm_pkg::sensor_state_t state_o
);
  import esrm_pkg::*;

  sensor_state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (cmd_i.soft_reset) begin
      state_d.hum_control   = '0;
      state_d.meas_control  = '0;
      state_d.filter_config = '0;
      state_d.temp_reading  = TEMP_RESET;
      state_d.press_reading = PRESS_RESET;
      state_d.hum_reading   = HUM_RESET;
    end
    if (cmd_i.hum_we)  state_d.hum_control   = cmd_i.wdata[2:0];
    if (cmd_i.meas_we) state_d.meas_control  = cmd_i.wdata;
    if (cmd_i.cfg_we)  state_d.filter_config = cmd_i.wdata;
    if (cmd_i.load) begin
      state_d.temp_reading  = cmd_i.raw_temperature;
      state_d.press_reading = cmd_i.raw_pressure;
      state_d.hum_reading   = cmd_i.raw_humidity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hum_control   <= '0;
      state_q.meas_control  <= '0;
      state_q.filter_config <= '0;
      state_q.temp_reading  <= TEMP_RESET;
      state_q.press_reading <= PRESS_RESET;
      state_q.hum_reading   <= HUM_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[rtl/core/esrm_rdmux.sv]
// Read decode of the sensor register model: trim ROM, data bytes, id and control registers.
// Depends on esrm_pkg.
module esrm_rdmux (
  input  logic [7:0]              addr_i,
  input  esrm_pkg::sensor_state_t state_i,
  output logic [7:0]              rdata_o
);
  import esrm_pkg::*;

  logic [7:0] off_a, off_b, off_d;
  logic [7:0] data_byte;

  assign off_a = addr_i - ADDR_TRIM_A;
  assign off_b = addr_i - ADDR_TRIM_B;
  assign off_d = addr_i - ADDR_DATA;

  // Readings are left aligned: the xlsb bytes carry the low nibble in their upper half.
  always_comb begin
    case (off_d[2:0])
      3'd0:    data_byte = state_i.press_reading[19:12];
      3'd1:    data_byte = state_i.press_reading[11:4];
      3'd2:    data_byte = {state_i.press_reading[3:0], 4'h0};
      3'd3:    data_byte = state_i.temp_reading[19:12];
      3'd4:    data_byte = state_i.temp_reading[11:4];
      3'd5:    data_byte = {state_i.temp_reading[3:0], 4'h0};
      3'd6:    data_byte = state_i.hum_reading[15:8];
      default: data_byte = state_i.hum_reading[7:0];
    endcase
  end

  always_comb begin
    if (addr_i >= ADDR_TRIM_A && addr_i <= ADDR_TRIM_A_END) begin
      rdata_o = trim_a_byte(off_a[4:0]);
    end else if (addr_i >= ADDR_TRIM_B && addr_i <= ADDR_TRIM_B_END) begin
      rdata_o = trim_b_byte(off_b[2:0]);
    end else if (addr_i >= ADDR_DATA && addr_i <= ADDR_DATA_END) begin
      rdata_o = data_byte;
    end else begin
      case (addr_i)
        ADDR_ID:        rdata_o = CHIP_ID;
        ADDR_STATUS:    rdata_o = 8'h00;
        ADDR_CTRL_HUM:  rdata_o = {5'b0, state_i.hum_control};
        ADDR_CTRL_MEAS: rdata_o = state_i.meas_control;
        ADDR_CONFIG:    rdata_o = state_i.filter_config;
        default:        rdata_o = 8'h00;
      endcase
    end
  end

endmodule

[rtl/core/env_sensor_register_model_top.sv]
// Sensor register model top level: an input register, the register bank and read decode,
// and an output register. A read word's data passes through the input register and then the
// output register before it is valid on the output; writes and loads give no word. One word
// is accepted per cycle while the output side keeps up; throughput is set by the single
// output register. Asynchronous active-low reset empties both stages and returns the
// registers and raw readings to their default values.
module env_sensor_register_model_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  esrm_in_if.sink    in_i,
  esrm_out_if.source out_o
);
  import esrm_pkg::*;

  // Input register stage.
  logic        s1_valid_q;
  logic [1:0]  s1_func_q;
  logic [7:0]  s1_addr_q;
  logic [7:0]  s1_wdata_q;
  logic [19:0] s1_temp_q;
  logic [19:0] s1_press_q;
  logic [15:0] s1_hum_q;

  // Output register stage.
  logic       out_valid_q;
  logic [7:0] out_rdata_q;

  logic          s1_is_read;
  logic          s1_adv;
  logic          in_fire;
  reg_cmd_t      cmd;
  sensor_state_t state;
  logic [7:0]    rd_byte;

  assign s1_is_read = (s1_func_q == FUNC_READ);

  // A word in the input register leaves when it needs no output slot, or the slot is
  // free or being emptied this cycle. State updates and reads both happen as it leaves,
  // so words see each other's effects in arrival order.
  assign s1_adv   = s1_valid_q && (!s1_is_read || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    cmd = '0;
    cmd.wdata           = s1_wdata_q;
    cmd.raw_temperature = s1_temp_q;
    cmd.raw_pressure    = s1_press_q;
    cmd.raw_humidity    = s1_hum_q;
    if (s1_adv && s1_func_q == FUNC_WRITE) begin
      cmd.soft_reset = (s1_addr_q == ADDR_RESET) && (s1_wdata_q == RESET_CMD);
      cmd.hum_we     = (s1_addr_q == ADDR_CTRL_HUM);
      cmd.meas_we    = (s1_addr_q == ADDR_CTRL_MEAS);
      cmd.cfg_we     = (s1_addr_q == ADDR_CONFIG);
    end
    cmd.load = s1_adv && (s1_func_q == FUNC_LOAD);
  end

  esrm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .state_o (state)
  );

  esrm_rdmux u_rdmux (
    .addr_i  (s1_addr_q),
    .state_i (state),
    .rdata_o (rd_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_is_read) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q  <= in_i.func;
      s1_addr_q  <= in_i.addr;
      s1_wdata_q <= in_i.wdata;
      s1_temp_q  <= in_i.raw_temperature;
      s1_press_q <= in_i.raw_pressure;
      s1_hum_q   <= in_i.raw_humidity;
    end
    if (s1_adv && s1_is_read) begin
      out_rdata_q <= rd_byte;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.rdata = out_rdata_q;

endmodule
